// File: hw/rtl/pdlb_pkg.sv
// package for the packed display list builder
// shared constants, action and error codes, controller/datapath command and status types
// no dependencies
package pdlb_pkg;

  localparam int unsigned PARAM_SLOTS = 8;
  localparam int unsigned MAX_LISTS   = 1024;
  localparam int unsigned IDS_PER_WORD = 4;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned ID_W    = 8;
  localparam int unsigned FILL_W  = 16;
  localparam int unsigned LIST_W  = $clog2(MAX_LISTS);
  localparam int unsigned PC_W    = $clog2(PARAM_SLOTS + 1);
  localparam int unsigned PIDX_W  = $clog2(PARAM_SLOTS);
  localparam int unsigned IDC_W   = $clog2(IDS_PER_WORD);
  localparam int unsigned ACT_W   = 2;
  localparam int unsigned ERR_W   = 2;
  localparam int unsigned M_DATA_W = 64;

  localparam logic [FILL_W-1:0] CAP_RESET = 16'd4096;
  localparam logic [ID_W-1:0]   NOP_ID    = 8'h00;

  typedef enum logic [ACT_W-1:0] {
    ACT_START  = 2'd0,
    ACT_ID     = 2'd1,
    ACT_PARAM  = 2'd2,
    ACT_FINISH = 2'd3
  } pdlb_act_e;

  localparam logic [ERR_W-1:0] ERR_NONE = 2'd0;
  localparam logic [ERR_W-1:0] ERR_CAP  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_OVF  = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,       // capture input word
    OP_OPEN,       // start a list
    OP_ERR_OUT,    // emit latched error result
    OP_ADD_ID,
    OP_PACK,       // emit packed id word
    OP_ADD_PARAM,
    OP_OVF_OUT,    // emit parameter overflow result
    OP_PARAM_OUT,  // emit one buffered parameter
    OP_HEADER_OUT  // emit size header and open the next list
  } pdlb_op_e;

  typedef struct packed {
    pdlb_op_e op;
    logic     last;
    logic     flush;  // pack finished: drop ids and params, latch error
  } pdlb_cmd_t;

  typedef struct packed {
    pdlb_act_e act;
    logic      latch_nz;
    logic      idc_full;   // three ids held, next id completes the pack
    logic      idc_zero;
    logic      pc_zero;
    logic      pc_full;
    logic      cap_err;
    logic      err_nz;
    logic      par_last;
    logic      out_free;
  } pdlb_stat_t;

endpackage

// File: hw/rtl/pdlb_ctrl.sv
// controller state machine for the packed display list builder
// sequences one input word into datapath commands; depends on pdlb_pkg
module pdlb_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  input  pdlb_pkg::pdlb_stat_t stat_i,
  output pdlb_pkg::pdlb_cmd_t  cmd_o
);
  import pdlb_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_PARAM,
    ST_HEADER
  } state_e;

  state_e state_q, state_d;

  assign s_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    cmd_o.op    = OP_NONE;
    cmd_o.last  = 1'b0;
    cmd_o.flush = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat_i.out_free) begin
          state_d = ST_IDLE;
          if (stat_i.act == ACT_START) begin
            cmd_o.op = OP_OPEN;
          end else if (stat_i.latch_nz) begin
            cmd_o.op   = OP_ERR_OUT;
            cmd_o.last = 1'b1;
          end else begin
            unique case (stat_i.act)
              ACT_ID: begin
                if (stat_i.idc_full) begin
                  cmd_o.op    = OP_PACK;
                  cmd_o.last  = stat_i.pc_zero;
                  cmd_o.flush = stat_i.pc_zero;
                  if (!stat_i.pc_zero) state_d = ST_PARAM;
                end else begin
                  cmd_o.op = OP_ADD_ID;
                end
              end
              ACT_PARAM: begin
                if (stat_i.pc_full) begin
                  cmd_o.op   = OP_OVF_OUT;
                  cmd_o.last = 1'b1;
                end else begin
                  cmd_o.op = OP_ADD_PARAM;
                end
              end
              ACT_FINISH: begin
                if (!stat_i.idc_zero) begin
                  cmd_o.op    = OP_PACK;
                  cmd_o.last  = stat_i.pc_zero && stat_i.cap_err;
                  cmd_o.flush = stat_i.pc_zero;
                  if (!stat_i.pc_zero) begin
                    state_d = ST_PARAM;
                  end else if (!stat_i.cap_err) begin
                    state_d = ST_HEADER;
                  end
                end else begin
                  cmd_o.op   = OP_HEADER_OUT;
                  cmd_o.last = 1'b1;
                end
              end
              default: cmd_o.op = OP_NONE;
            endcase
          end
        end
      end
      ST_PARAM: begin
        if (stat_i.out_free) begin
          cmd_o.op    = OP_PARAM_OUT;
          cmd_o.flush = stat_i.par_last;
          cmd_o.last  = stat_i.par_last &&
                        !((stat_i.act == ACT_FINISH) && !stat_i.err_nz);
          if (stat_i.par_last) begin
            state_d = ((stat_i.act == ACT_FINISH) && !stat_i.err_nz) ? ST_HEADER : ST_IDLE;
          end
        end
      end
      ST_HEADER: begin
        if (stat_i.out_free) begin
          cmd_o.op   = OP_HEADER_OUT;
          cmd_o.last = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: hw/rtl/pdlb_dpath.sv
// datapath for the packed display list builder
// id and parameter buffers, list counters, capacity register and output word register
// depends on pdlb_pkg
module pdlb_dpath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  pdlb_pkg::pdlb_cmd_t             cmd_i,
  output pdlb_pkg::pdlb_stat_t            stat_o,
  input  logic [pdlb_pkg::WORD_W-1:0]     in_value_i,
  input  logic [pdlb_pkg::ACT_W-1:0]      in_action_i,
  input  logic                            cfg_we_i,
  input  logic [pdlb_pkg::FILL_W-1:0]     cfg_wdata_i,
  input  logic                            m_ready_i,
  output logic                            m_valid_o,
  output logic [pdlb_pkg::WORD_W-1:0]     m_word_o,
  output logic [pdlb_pkg::FILL_W-1:0]     m_index_o,
  output logic [pdlb_pkg::LIST_W-1:0]     m_list_o,
  output logic                            m_last_o,
  output logic [pdlb_pkg::ERR_W-1:0]      m_err_o
);
  import pdlb_pkg::*;

  pdlb_act_e                 act_q;
  logic [WORD_W-1:0]         val_q;
  logic [ID_W-1:0]           ids_q [IDS_PER_WORD];
  logic [IDC_W-1:0]          idc_q;
  logic [WORD_W-1:0]         par_q [PARAM_SLOTS];
  logic [PC_W-1:0]           pc_q;
  logic [PIDX_W-1:0]         pidx_q;
  logic [FILL_W-1:0]         fill_q;
  logic [LIST_W-1:0]         list_q;
  logic [ERR_W-1:0]          latch_q;
  logic [ERR_W-1:0]          err_q;
  logic [FILL_W-1:0]         cap_q;
  logic                      ov_q;

  logic [ID_W-1:0]           ids_eff [IDS_PER_WORD];
  logic [WORD_W-1:0]         pack_word;
  logic [FILL_W:0]           fill_sum;
  logic [FILL_W-1:0]         fill_after;
  logic [FILL_W-1:0]         fill_inc;
  logic                      cap_err;
  logic                      out_free;
  logic                      emit;
  logic [ERR_W-1:0]          flush_err;

  // the id that completes a pack goes straight into the word
  always_comb begin
    for (int i = 0; i < IDS_PER_WORD; i++) ids_eff[i] = ids_q[i];
    if (act_q == ACT_ID) ids_eff[idc_q] = val_q[ID_W-1:0];
  end
  assign pack_word = {ids_eff[3], ids_eff[2], ids_eff[1], ids_eff[0]};

  // fill once the pack and its params are out, saturating
  assign fill_sum   = {1'b0, fill_q} + (FILL_W+1)'(pc_q) + (FILL_W+1)'(1);
  assign fill_after = fill_sum[FILL_W] ? '1 : fill_sum[FILL_W-1:0];
  assign cap_err    = (fill_after >= cap_q);
  assign fill_inc   = (fill_q == '1) ? fill_q : fill_q + FILL_W'(1);

  assign out_free = !ov_q || m_ready_i;
  assign emit     = (cmd_i.op == OP_ERR_OUT) || (cmd_i.op == OP_PACK) ||
                    (cmd_i.op == OP_OVF_OUT) || (cmd_i.op == OP_PARAM_OUT) ||
                    (cmd_i.op == OP_HEADER_OUT);
  assign flush_err = (cmd_i.op == OP_PACK) ? (cap_err ? ERR_CAP : ERR_NONE) : err_q;

  assign stat_o.act      = act_q;
  assign stat_o.latch_nz = (latch_q != ERR_NONE);
  assign stat_o.idc_full = (idc_q == IDC_W'(IDS_PER_WORD - 1));
  assign stat_o.idc_zero = (idc_q == '0);
  assign stat_o.pc_zero  = (pc_q == '0);
  assign stat_o.pc_full  = (pc_q == PC_W'(PARAM_SLOTS));
  assign stat_o.cap_err  = cap_err;
  assign stat_o.err_nz   = (err_q != ERR_NONE);
  assign stat_o.par_last = ((PC_W'(pidx_q) + PC_W'(1)) == pc_q);
  assign stat_o.out_free = out_free;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q   <= ACT_START;
      for (int i = 0; i < IDS_PER_WORD; i++) ids_q[i] <= NOP_ID;
      idc_q   <= '0;
      pc_q    <= '0;
      pidx_q  <= '0;
      fill_q  <= FILL_W'(1);
      list_q  <= '0;
      latch_q <= ERR_NONE;
      err_q   <= ERR_NONE;
      cap_q   <= CAP_RESET;
      ov_q    <= 1'b0;
    end else begin
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      if (emit) begin
        ov_q <= 1'b1;
      end else if (m_ready_i) begin
        ov_q <= 1'b0;
      end
      unique case (cmd_i.op)
        OP_LOAD: act_q <= pdlb_act_e'(in_action_i);
        OP_OPEN: begin
          for (int i = 0; i < IDS_PER_WORD; i++) ids_q[i] <= NOP_ID;
          idc_q   <= '0;
          pc_q    <= '0;
          fill_q  <= FILL_W'(1);
          latch_q <= ERR_NONE;
        end
        OP_ADD_ID: begin
          ids_q[idc_q] <= val_q[ID_W-1:0];
          idc_q        <= idc_q + IDC_W'(1);
        end
        OP_PACK: begin
          err_q  <= cap_err ? ERR_CAP : ERR_NONE;
          fill_q <= fill_inc;
          pidx_q <= '0;
        end
        OP_ADD_PARAM: pc_q <= pc_q + PC_W'(1);
        OP_OVF_OUT:   latch_q <= ERR_OVF;
        OP_PARAM_OUT: begin
          fill_q <= fill_inc;
          pidx_q <= pidx_q + PIDX_W'(1);
        end
        OP_HEADER_OUT: begin
          list_q <= (list_q == LIST_W'(MAX_LISTS - 1)) ? '0 : list_q + LIST_W'(1);
          fill_q <= FILL_W'(1);
          // next list opens empty, params left without ids are dropped
          idc_q  <= '0;
          pc_q   <= '0;
        end
        default: ;
      endcase
      if (cmd_i.flush) begin
        for (int i = 0; i < IDS_PER_WORD; i++) ids_q[i] <= NOP_ID;
        idc_q   <= '0;
        pc_q    <= '0;
        latch_q <= flush_err;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD) val_q <= in_value_i;
    if (cmd_i.op == OP_ADD_PARAM) par_q[pc_q[PIDX_W-1:0]] <= val_q;
    if (emit) begin
      m_list_o <= list_q;
      m_last_o <= cmd_i.last;
    end
    unique case (cmd_i.op)
      OP_ERR_OUT: begin
        m_word_o  <= '0;
        m_index_o <= '0;
        m_err_o   <= latch_q;
      end
      OP_PACK: begin
        m_word_o  <= pack_word;
        m_index_o <= fill_q;
        m_err_o   <= cap_err ? ERR_CAP : ERR_NONE;
      end
      OP_OVF_OUT: begin
        m_word_o  <= '0;
        m_index_o <= '0;
        m_err_o   <= ERR_OVF;
      end
      OP_PARAM_OUT: begin
        m_word_o  <= par_q[pidx_q];
        m_index_o <= fill_q;
        m_err_o   <= err_q;
      end
      OP_HEADER_OUT: begin
        m_word_o  <= WORD_W'(fill_q - FILL_W'(1));
        m_index_o <= '0;
        m_err_o   <= ERR_NONE;
      end
      default: ;
    endcase
  end

  assign m_valid_o = ov_q;

endmodule

// File: hw/rtl/packed_display_list_builder.sv
// top level of the packed display list builder
// joins pdlb_ctrl and pdlb_dpath; depends on pdlb_pkg
//
// channel  | direction | tdata                               | tuser      | tlast
// s_axis   | in        | value[31:0]                         | action[1:0]| -
// m_axis   | out       | word, word_index, list_number, pad  | error[1:0] | last
// cfg      | in        | list_capacity[15:0], write on cfg_we_i
//
// one input word is accepted into a holding register and executed from it once the
// output register is free; no new item is accepted until the held one has executed
// a pack gives 1 + (buffered params) words and a finish adds the header unless the
// capacity error is hit, one word per cycle while m_axis is ready, through the single output register
// reset is immediate, no clearing pass; the parameter buffer needs no reset
// a stalled m_axis holds the output register and the next item waits in the
// holding register; s_axis_tready drops until that item has executed
module packed_display_list_builder (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // slave side
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [pdlb_pkg::WORD_W-1:0]       s_axis_tdata,  // [31:0] value
  input  logic [pdlb_pkg::ACT_W-1:0]        s_axis_tuser,  // [1:0] action
  // master side
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [pdlb_pkg::M_DATA_W-1:0]     m_axis_tdata,  // [31:0] word, [47:32] word_index,
                                                           // [57:48] list_number, [63:58] zero
  output logic [pdlb_pkg::ERR_W-1:0]        m_axis_tuser,  // [1:0] error
  output logic                              m_axis_tlast,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [pdlb_pkg::FILL_W-1:0]       cfg_wdata_i
);
  import pdlb_pkg::*;

  pdlb_cmd_t           cmd;
  pdlb_stat_t          stat;
  logic [WORD_W-1:0]   out_word;
  logic [FILL_W-1:0]   out_index;
  logic [LIST_W-1:0]   out_list;

  // controller: accepts one item, then walks pack, params and header
  pdlb_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  // datapath: buffers, counters, output word register
  pdlb_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_value_i  (s_axis_tdata),
    .in_action_i (s_axis_tuser),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .m_ready_i   (m_axis_tready),
    .m_valid_o   (m_axis_tvalid),
    .m_word_o    (out_word),
    .m_index_o   (out_index),
    .m_list_o    (out_list),
    .m_last_o    (m_axis_tlast),
    .m_err_o     (m_axis_tuser)
  );

  // pack result fields, first field lowest
  assign m_axis_tdata = {(M_DATA_W - WORD_W - FILL_W - LIST_W)'(0), out_list, out_index, out_word};

  // parameter overflow always ends its item with a single word
  a_ovf_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == ERR_OVF)) |-> m_axis_tlast)
    else $error("overflow result without last");

  // a size header is the final word of its item
  a_header_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == ERR_NONE) &&
     (m_axis_tdata[WORD_W +: FILL_W] == '0)) |-> m_axis_tlast)
    else $error("header result without last");

  // one item at a time: no accept right after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("back to back accept");

endmodule

// File: tb/tb_packed_display_list_builder.sv
// self-checking testbench for packed_display_list_builder
// drives action/value words, predicts every output word and compares field by field
// depends on pdlb_pkg and the packed_display_list_builder rtl
module tb_packed_display_list_builder;
  import pdlb_pkg::*;

  // one output word as the predictor sees it
  typedef struct {
    logic [WORD_W-1:0] word;
    logic [FILL_W-1:0] idx;
    logic [LIST_W-1:0] list;
    logic              last;
    logic [ERR_W-1:0]  err;
  } list_word_t;

  localparam int unsigned DRAIN_LIMIT = 20000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned PHASE_ITEMS = 35;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [WORD_W-1:0]   s_axis_tdata = '0;
  logic [ACT_W-1:0]    s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;
  logic [ERR_W-1:0]    m_axis_tuser;
  logic                m_axis_tlast;
  logic                cfg_we_i = 1'b0;
  logic [FILL_W-1:0]   cfg_wdata_i = '0;

  // predictor state, mirrors the block
  logic [ID_W-1:0]   ids_q [IDS_PER_WORD];
  int unsigned       id_cnt;
  logic [WORD_W-1:0] params_q [PARAM_SLOTS];
  int unsigned       par_cnt;
  logic [FILL_W-1:0] fill;
  logic [LIST_W-1:0] list_no;
  logic [ERR_W-1:0]  err_latch;
  logic [FILL_W-1:0] capacity;

  list_word_t batch [$];      // words caused by the item being predicted
  list_word_t due_words [$];  // predicted words not yet seen on m_axis

  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned words_seen = 0;
  int unsigned lists_closed = 0;
  int unsigned error_words = 0;

  // idling controls
  bit idle_off = 1'b0;   // no gaps on either side
  int hold_left = 0;     // long receiver hold-off, counted down at each falling edge
  int rcv_wait = 0;      // per-word receiver gap

  packed_display_list_builder u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // [31:0] value
    .s_axis_tuser (s_axis_tuser),   // [1:0] action
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // [31:0] word, [47:32] word_index, [57:48] list_number
    .m_axis_tuser (m_axis_tuser),   // [1:0] error
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  task automatic open_list();
    for (int i = 0; i < IDS_PER_WORD; i++) ids_q[i] = '0;
    for (int i = 0; i < PARAM_SLOTS; i++) params_q[i] = '0;
    id_cnt  = 0;
    par_cnt = 0;
    fill    = 16'd1;  // header slot reserved
  endtask

  task automatic add_word(logic [WORD_W-1:0] w, logic [FILL_W-1:0] idx);
    list_word_t r;
    r.word = w;
    r.idx  = idx;
    r.list = list_no;
    r.last = 1'b0;
    r.err  = ERR_NONE;
    batch.push_back(r);
  endtask

  // fill saturates at all ones
  task automatic bump_fill();
    if (fill != '1) fill = fill + 1'b1;
  endtask

  // packed id word, then the buffered params, each at the next position
  task automatic emit_pack();
    add_word({ids_q[3], ids_q[2], ids_q[1], ids_q[0]}, fill);
    bump_fill();
    for (int i = 0; i < par_cnt; i++) begin
      add_word(params_q[i], fill);
      bump_fill();
    end
    for (int i = 0; i < IDS_PER_WORD; i++) ids_q[i] = '0;
    for (int i = 0; i < PARAM_SLOTS; i++) params_q[i] = '0;
    id_cnt  = 0;
    par_cnt = 0;
  endtask

  task automatic predict_list_words(pdlb_act_e act, logic [WORD_W-1:0] val);
    logic [ERR_W-1:0] e;
    e = ERR_NONE;
    batch.delete();
    if (act == ACT_START) begin
      // restart keeps the list number
      open_list();
      err_latch = ERR_NONE;
      return;
    end
    if (err_latch != ERR_NONE) begin
      // latched error: item dropped, one error word
      add_word('0, '0);
      e = err_latch;
    end else begin
      case (act)
        ACT_ID: begin
          ids_q[id_cnt] = val[ID_W-1:0];
          id_cnt++;
          if (id_cnt == IDS_PER_WORD) begin
            emit_pack();
            if (fill >= capacity) e = ERR_CAP;
          end
        end
        ACT_PARAM: begin
          if (par_cnt >= PARAM_SLOTS) begin
            add_word('0, '0);
            e = ERR_OVF;
          end else begin
            params_q[par_cnt] = val;
            par_cnt++;
          end
        end
        default: begin
          // finish: pad a partial pack with nop ids; params with no ids are dropped
          if (id_cnt > 0) begin
            while (id_cnt < IDS_PER_WORD) begin
              ids_q[id_cnt] = NOP_ID;
              id_cnt++;
            end
            emit_pack();
            if (fill >= capacity) e = ERR_CAP;
          end
          if (e == ERR_NONE) begin
            add_word(WORD_W'(fill) - 1, '0);
            list_no = (list_no == LIST_W'(MAX_LISTS - 1)) ? '0 : list_no + 1'b1;
            lists_closed++;
            open_list();
          end
        end
      endcase
    end
    if (e != ERR_NONE) begin
      err_latch = e;
      error_words += batch.size();
    end
    foreach (batch[k]) begin
      batch[k].err  = e;
      batch[k].last = (k == batch.size() - 1);
      due_words.push_back(batch[k]);
    end
  endtask

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic check_word();
    list_word_t want;
    if (due_words.size() == 0) begin
      report_mismatch("word with nothing due", m_axis_tdata, '0);
      return;
    end
    want = due_words.pop_front();
    words_seen++;
    if (m_axis_tdata[31:0] !== want.word) report_mismatch("word", m_axis_tdata[31:0], want.word);
    if (m_axis_tdata[47:32] !== want.idx) report_mismatch("word_index", m_axis_tdata[47:32], want.idx);
    if (m_axis_tdata[57:48] !== want.list)
      report_mismatch("list_number", m_axis_tdata[57:48], want.list);
    if (m_axis_tlast !== want.last) report_mismatch("last", m_axis_tlast, want.last);
    if (m_axis_tuser !== want.err) report_mismatch("error", m_axis_tuser, want.err);
  endtask

  // random gap before the next word on either side; none when idle_off is set
  function automatic int draw_gap();
    if (idle_off) return 0;
    if ($urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 18);
  endfunction

  // receiver ready, changed only at the falling edge; hold-off wins over the per-word gap
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (rcv_wait > 0) begin
      rcv_wait--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rst_ni;
    end
  end

  // sample accepted output words at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      check_word();
      rcv_wait = draw_gap();
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // offer one item after a random gap, predict it once it is taken
  task automatic send_word(pdlb_act_e act, logic [WORD_W-1:0] val);
    int g;
    g = draw_gap();
    @(negedge clk_i);
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= val;
    s_axis_tuser  <= act;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_list_words(act, val);
    items_sent++;
  endtask

  // pause the sender until every predicted word has come, then let the block settle
  task automatic wait_idle();
    int n;
    n = 0;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (due_words.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk_i);
      n++;
    end
    if (due_words.size() != 0) begin
      report_mismatch("words never produced", due_words.size(), 0);
      due_words.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // only called while idle
  task automatic set_capacity(logic [FILL_W-1:0] c);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= c;
    @(posedge clk_i);
    capacity = c;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // four ids and n_par params in random order, always ending on the id that packs
  task automatic send_pack(int n_par);
    int ids_left;
    int par_left;
    ids_left = IDS_PER_WORD;
    par_left = n_par;
    while (ids_left > 0) begin
      if (par_left == 0 || (ids_left > 1 && $urandom_range(0, 1) == 1)) begin
        send_word(ACT_ID, $urandom());
        ids_left--;
      end else begin
        send_word(ACT_PARAM, $urandom());
        par_left--;
      end
    end
  endtask

  // a well-formed list with random content, sometimes left open
  task automatic send_random_list();
    int tail;
    if (err_latch != ERR_NONE || $urandom_range(0, 3) == 0) send_word(ACT_START, $urandom());
    repeat ($urandom_range(0, 3)) begin
      // mostly few params, now and then a full buffer
      send_pack(($urandom_range(0, 3) == 0) ? PARAM_SLOTS : $urandom_range(0, 3));
    end
    tail = $urandom_range(0, 3);
    repeat (tail) send_word(ACT_ID, $urandom());
    if ($urandom_range(0, 2) == 0) send_word(ACT_PARAM, $urandom());
    if ($urandom_range(0, 7) != 0) send_word(ACT_FINISH, $urandom());
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // basic lists at the reset capacity: packing order, padding, empty lists, restart
  task automatic test_directed_lists();
    send_word(ACT_START, 32'h0);
    send_word(ACT_ID, 32'h0000_0000);
    send_word(ACT_ID, 32'hFFFF_FFFF);      // only the low byte is the id
    send_word(ACT_PARAM, 32'h0000_0000);
    send_word(ACT_PARAM, 32'hFFFF_FFFF);
    send_word(ACT_ID, 32'h1234_56A5);
    send_word(ACT_ID, 32'h0000_005A);      // pack 0x5AA5FF00 then both params
    send_word(ACT_ID, 32'h0000_0011);
    send_word(ACT_FINISH, 32'hFFFF_FFFF);  // padded pack then header
    send_word(ACT_FINISH, 32'h0);          // empty list, header only
    send_word(ACT_PARAM, 32'h1234_5678);
    send_word(ACT_FINISH, 32'h0);          // params with no ids are dropped
    send_word(ACT_ID, 32'h0000_0022);
    send_word(ACT_START, 32'hFFFF_FFFF);   // restart drops the pending id
    send_word(ACT_ID, 32'h0000_0033);
    send_word(ACT_FINISH, 32'h0);
    wait_idle();
  endtask

  // ninth param overflows; the latched error then answers ids, params and finish
  task automatic test_param_overflow();
    send_word(ACT_START, 32'h0);
    repeat (PARAM_SLOTS + 1) send_word(ACT_PARAM, $urandom());
    send_word(ACT_ID, 32'h0000_0077);
    send_word(ACT_PARAM, 32'hDEAD_BEEF);
    send_word(ACT_FINISH, 32'h0);
    send_word(ACT_START, 32'h0);           // clears the latch
    wait_idle();
  endtask

  // a capacity of two or less fails on the first pack; a finish that hits capacity has no header
  task automatic test_capacity_limit();
    set_capacity(16'd1);
    send_word(ACT_START, 32'h0);
    repeat (IDS_PER_WORD) send_word(ACT_ID, $urandom());
    send_word(ACT_FINISH, 32'h0);
    wait_idle();
    set_capacity(16'd3);
    send_word(ACT_START, 32'h0);
    send_word(ACT_PARAM, 32'hA5A5_5A5A);
    send_word(ACT_ID, 32'h0000_00C3);
    send_word(ACT_FINISH, 32'h0);          // pack and param reach fill 3, no header
    send_word(ACT_START, 32'h0);
    wait_idle();
  endtask

  // receiver holds off while the sender keeps going, then the sender waits for the drain
  task automatic test_backpressure();
    set_capacity(CAP_RESET);
    idle_off = 1'b1;
    hold_left = 400;
    send_word(ACT_START, 32'h0);
    repeat (4) send_pack(PARAM_SLOTS);
    send_word(ACT_FINISH, 32'h0);
    wait_idle();
    idle_off = 1'b0;
    send_random_list();
    wait_idle();
  endtask

  // random lists across several capacities, extremes included
  task automatic test_random_lists();
    logic [FILL_W-1:0] caps [6];
    int unsigned base;
    int r;
    caps[0] = 16'd2;
    caps[1] = 16'hFFFF;
    caps[2] = CAP_RESET;
    caps[3] = FILL_W'($urandom_range(3, 40));
    caps[4] = FILL_W'($urandom_range(3, 16));
    caps[5] = FILL_W'($urandom_range(2, 65535));
    foreach (caps[p]) begin
      set_capacity(caps[p]);
      idle_off = ($urandom_range(0, 4) == 0);  // some phases run without gaps
      base = items_sent;
      while (items_sent - base < PHASE_ITEMS) begin
        r = $urandom_range(0, 9);
        if (r < 8) begin
          send_random_list();
        end else if (r == 8) begin
          repeat ($urandom_range(1, 4)) send_word(pdlb_act_e'($urandom_range(0, 3)), $urandom());
        end else begin
          repeat ($urandom_range(PARAM_SLOTS + 1, PARAM_SLOTS + 3))
            send_word(ACT_PARAM, $urandom());
        end
      end
      wait_idle();
    end
    idle_off = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // run
  // ---------------------------------------------------------------------------

  initial begin
    capacity  = CAP_RESET;
    list_no   = '0;
    err_latch = ERR_NONE;
    open_list();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_directed_lists();
    test_param_overflow();
    test_capacity_limit();
    test_backpressure();
    test_random_lists();
    wait_idle();

    $display("run covered %0d items and %0d output words: %0d lists closed, %0d error words",
             items_sent, words_seen, lists_closed, error_words);
    $display("capacities from 1 to 65535, parameter overflow, latched errors and output stalls");
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog, well beyond the slowest legal run
  initial begin
    #24000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
